>>> rtl/pat_pkg.sv
package pat_pkg;

    typedef enum logic [1:0] {
        FUNC_TRANSLATE = 2'd0,
        FUNC_ROTATE    = 2'd1,
        FUNC_SCALE     = 2'd2,
        FUNC_COMPOSITE = 2'd3
    } func_t;

    localparam logic [2:0] CFG_SHIFT_X  = 3'd0;
    localparam logic [2:0] CFG_SHIFT_Y  = 3'd1;
    localparam logic [2:0] CFG_ROTATION = 3'd2;
    localparam logic [2:0] CFG_SCALE_X  = 3'd3;
    localparam logic [2:0] CFG_SCALE_Y  = 3'd4;
    localparam logic [2:0] CFG_PIVOT_X  = 3'd5;
    localparam logic [2:0] CFG_PIVOT_Y  = 3'd6;

    // Angle path in units of 2^-16 degree
    localparam int Z_W = 28;
    localparam logic signed [Z_W-1:0] DEG_90  = 28'sd5898240;
    localparam logic signed [Z_W-1:0] DEG_180 = 28'sd11796480;
    localparam logic signed [Z_W-1:0] DEG_360 = 28'sd23592960;

    // CORDIC vector in Q4.30, start at 1/gain
    localparam int CV_W = 34;
    localparam logic signed [CV_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // atan(2^-i) in degrees times 65536
    function automatic logic signed [Z_W-1:0] atan_deg(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        begin
            case (idx)
                5'd0:    v = 28'sd2949120;
                5'd1:    v = 28'sd1740967;
                5'd2:    v = 28'sd919879;
                5'd3:    v = 28'sd466945;
                5'd4:    v = 28'sd234379;
                5'd5:    v = 28'sd117304;
                5'd6:    v = 28'sd58666;
                5'd7:    v = 28'sd29335;
                5'd8:    v = 28'sd14668;
                5'd9:    v = 28'sd7334;
                5'd10:   v = 28'sd3667;
                5'd11:   v = 28'sd1833;
                5'd12:   v = 28'sd917;
                5'd13:   v = 28'sd458;
                5'd14:   v = 28'sd229;
                5'd15:   v = 28'sd115;
                5'd16:   v = 28'sd57;
                5'd17:   v = 28'sd29;
                5'd18:   v = 28'sd14;
                5'd19:   v = 28'sd7;
                5'd20:   v = 28'sd4;
                5'd21:   v = 28'sd2;
                5'd22:   v = 28'sd1;
                default: v = 28'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> rtl/point_affine_transform.sv
// 2D affine transform of Q16.16 points. Each item carries an operation code
// (translate, rotate about the pivot, scale about the pivot, or the composite
// translate -> rotate about origin -> scale about origin) and one point; each
// item gives one result with a saturation flag. The datapath is a five-stage
// pipeline (translate/center, rotation products, rotation round/clamp, scale
// products, scale round/clamp) that takes one item per clock unless out_stall
// holds the pipe. Sine and cosine are not computed per item: a shared
// iterative CORDIC, one micro-rotation per clock, recomputes them after reset
// and after every write of rotation_angle; during that run in_stall is held
// high. Configuration writes are always taken (cfg_ready is tied high).
// Coordinates clamp to the signed range of min(COORD_WIDTH, 32) bits.
module point_affine_transform #(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_WIDTH   = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] result_x,
    output logic signed [31:0] result_y,
    output logic               saturated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int SAT_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int CNT_W    = $clog2(CORDIC_STAGES);
    localparam int TRIG_W   = 20;
    localparam int P_W      = 33 + TRIG_W;
    localparam int M_W      = 49;
    localparam logic signed [47:0] SAT_HI = (48'sd1 <<< (SAT_BITS - 1)) - 48'sd1;
    localparam logic signed [47:0] SAT_LO = -SAT_HI - 48'sd1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STAGES - 1);

    // Clamp to the saturation range; bit 32 is the clamp flag.
    function automatic logic [32:0] sat(input logic signed [47:0] v);
        logic [32:0] r;
        begin
            if (v > SAT_HI)
            begin
                r = {1'b1, SAT_HI[31:0]};
            end
            else if (v < SAT_LO)
            begin
                r = {1'b1, SAT_LO[31:0]};
            end
            else
            begin
                r = {1'b0, v[31:0]};
            end
            return r;
        end
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic signed [31:0] shift_x_reg, shift_y_reg, pivot_x_reg, pivot_y_reg;
    logic signed [15:0] scale_x_reg, scale_y_reg;
    logic               cfg_fire;
    logic               angle_wr;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign angle_wr  = cfg_fire && (cfg_index == pat_pkg::CFG_ROTATION);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_x_reg <= '0;
            shift_y_reg <= '0;
            scale_x_reg <= 16'sd256;
            scale_y_reg <= 16'sd256;
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                pat_pkg::CFG_SHIFT_X: shift_x_reg <= cfg_data;
                pat_pkg::CFG_SHIFT_Y: shift_y_reg <= cfg_data;
                pat_pkg::CFG_SCALE_X: scale_x_reg <= cfg_data[15:0];
                pat_pkg::CFG_SCALE_Y: scale_y_reg <= cfg_data[15:0];
                pat_pkg::CFG_PIVOT_X: pivot_x_reg <= cfg_data;
                pat_pkg::CFG_PIVOT_Y: pivot_y_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sine/cosine: iterative CORDIC, restarted on every angle write
    // ---------------------------------------------------------------
    logic signed [pat_pkg::Z_W-1:0]  z_reg, z_next, z_load, z_red;
    logic signed [pat_pkg::CV_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            neg_reg, neg_next, neg_load;
    logic signed [TRIG_W-1:0]        cos_reg, cos_next, sin_reg, sin_next;
    logic signed [pat_pkg::CV_W-1:0] xs, ys, xr, yr;
    logic signed [TRIG_W-1:0]        cos_rnd, sin_rnd;

    // Reduce the new angle to [-180, 180], then fold to [-90, 90]
    always_comb
    begin
        z_red = pat_pkg::Z_W'(signed'(cfg_data[15:0])) <<< 10;
        if (z_red > pat_pkg::DEG_180)
        begin
            z_red = z_red - pat_pkg::DEG_360;
        end
        else if (z_red < -pat_pkg::DEG_180)
        begin
            z_red = z_red + pat_pkg::DEG_360;
        end
        neg_load = 1'b0;
        z_load   = z_red;
        if (z_red > pat_pkg::DEG_90)
        begin
            z_load   = z_red - pat_pkg::DEG_180;
            neg_load = 1'b1;
        end
        else if (z_red < -pat_pkg::DEG_90)
        begin
            z_load   = z_red + pat_pkg::DEG_180;
            neg_load = 1'b1;
        end
    end

    always_comb
    begin
        xs = cx_reg >>> cnt_reg;
        ys = cy_reg >>> cnt_reg;
        if (z_reg >= 0)
        begin
            xr = cx_reg - ys;
            yr = cy_reg + xs;
        end
        else
        begin
            xr = cx_reg + ys;
            yr = cy_reg - xs;
        end
        cos_rnd = TRIG_W'((xr + pat_pkg::CV_W'(8192)) >>> 14);
        sin_rnd = TRIG_W'((yr + pat_pkg::CV_W'(8192)) >>> 14);

        z_next    = z_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        cos_next  = cos_reg;
        sin_next  = sin_reg;
        if (angle_wr)
        begin
            z_next    = z_load;
            neg_next  = neg_load;
            cx_next   = pat_pkg::CORDIC_GAIN_Q30;
            cy_next   = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            cx_next = xr;
            cy_next = yr;
            if (z_reg >= 0)
            begin
                z_next = z_reg - pat_pkg::atan_deg(5'(cnt_reg));
            end
            else
            begin
                z_next = z_reg + pat_pkg::atan_deg(5'(cnt_reg));
            end
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                cos_next  = neg_reg ? -cos_rnd : cos_rnd;
                sin_next  = neg_reg ? -sin_rnd : sin_rnd;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    // Reset starts a run for angle zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_reg    <= '0;
            cx_reg   <= pat_pkg::CORDIC_GAIN_Q30;
            cy_reg   <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            neg_reg  <= 1'b0;
            cos_reg  <= '0;
            sin_reg  <= '0;
        end
        else
        begin
            z_reg    <= z_next;
            cx_reg   <= cx_next;
            cy_reg   <= cy_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            neg_reg  <= neg_next;
            cos_reg  <= cos_next;
            sin_reg  <= sin_next;
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: all stages advance together unless the output holds
    // ---------------------------------------------------------------
    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    assign adv       = !(v5_reg && out_stall);
    assign in_stall  = busy_reg || !adv;
    assign out_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid && !busy_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: translate and center on the pivot (origin for composite)
    // ---------------------------------------------------------------
    pat_pkg::func_t     f_in, f1_reg, f2_reg, f3_reg, f4_reg;
    logic [32:0]        tx_sat, ty_sat;
    logic signed [31:0] t_x, t_y, c_x, c_y;
    logic               t_flag;
    logic signed [31:0] t1x_reg, t1y_reg, c1x_reg, c1y_reg;
    logic signed [32:0] d1x_reg, d1y_reg;
    logic               fl1_reg;

    assign f_in = pat_pkg::func_t'(func);

    always_comb
    begin
        tx_sat = sat(48'(point_x) + 48'(shift_x_reg));
        ty_sat = sat(48'(point_y) + 48'(shift_y_reg));
        if (f_in == pat_pkg::FUNC_TRANSLATE || f_in == pat_pkg::FUNC_COMPOSITE)
        begin
            t_x    = tx_sat[31:0];
            t_y    = ty_sat[31:0];
            t_flag = tx_sat[32] | ty_sat[32];
        end
        else
        begin
            t_x    = point_x;
            t_y    = point_y;
            t_flag = 1'b0;
        end
        if (f_in == pat_pkg::FUNC_COMPOSITE)
        begin
            c_x = '0;
            c_y = '0;
        end
        else
        begin
            c_x = pivot_x_reg;
            c_y = pivot_y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg  <= f_in;
            t1x_reg <= t_x;
            t1y_reg <= t_y;
            c1x_reg <= c_x;
            c1y_reg <= c_y;
            d1x_reg <= 33'(t_x) - 33'(c_x);
            d1y_reg <= 33'(t_y) - 33'(c_y);
            fl1_reg <= t_flag;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: rotation products
    // ---------------------------------------------------------------
    logic signed [31:0]    t2x_reg, t2y_reg, c2x_reg, c2y_reg;
    logic signed [32:0]    d2x_reg, d2y_reg;
    logic signed [P_W-1:0] xc_reg, ys_reg, xsn_reg, yc_reg;
    logic                  fl2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f2_reg  <= f1_reg;
            t2x_reg <= t1x_reg;
            t2y_reg <= t1y_reg;
            c2x_reg <= c1x_reg;
            c2y_reg <= c1y_reg;
            d2x_reg <= d1x_reg;
            d2y_reg <= d1y_reg;
            xc_reg  <= P_W'(d1x_reg) * P_W'(cos_reg);
            ys_reg  <= P_W'(d1y_reg) * P_W'(sin_reg);
            xsn_reg <= P_W'(d1x_reg) * P_W'(sin_reg);
            yc_reg  <= P_W'(d1y_reg) * P_W'(cos_reg);
            fl2_reg <= fl1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: round rotation, add center back, clamp
    // ---------------------------------------------------------------
    logic signed [P_W:0]   rsum_x, rsum_y;
    logic [32:0]           rx_sat, ry_sat;
    logic signed [31:0]    t3x_reg, t3y_reg, c3x_reg, c3y_reg, r3x_reg, r3y_reg;
    logic signed [32:0]    d3x_reg, d3y_reg;
    logic                  fl3_reg;
    logic                  rot_used;

    always_comb
    begin
        rsum_x = (P_W+1)'(xc_reg) - (P_W+1)'(ys_reg) + (P_W+1)'(32768);
        rsum_y = (P_W+1)'(xsn_reg) + (P_W+1)'(yc_reg) + (P_W+1)'(32768);
        rx_sat = sat(48'(rsum_x >>> 16) + 48'(c2x_reg));
        ry_sat = sat(48'(rsum_y >>> 16) + 48'(c2y_reg));
        rot_used = (f2_reg == pat_pkg::FUNC_ROTATE) || (f2_reg == pat_pkg::FUNC_COMPOSITE);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f3_reg  <= f2_reg;
            t3x_reg <= t2x_reg;
            t3y_reg <= t2y_reg;
            c3x_reg <= c2x_reg;
            c3y_reg <= c2y_reg;
            d3x_reg <= d2x_reg;
            d3y_reg <= d2y_reg;
            r3x_reg <= rx_sat[31:0];
            r3y_reg <= ry_sat[31:0];
            fl3_reg <= fl2_reg | (rot_used & (rx_sat[32] | ry_sat[32]));
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: scale products (composite scales the rotated point)
    // ---------------------------------------------------------------
    logic signed [32:0]    sd_x, sd_y;
    logic signed [31:0]    t4x_reg, t4y_reg, c4x_reg, c4y_reg, r4x_reg, r4y_reg;
    logic signed [M_W-1:0] m4x_reg, m4y_reg;
    logic                  fl4_reg;

    always_comb
    begin
        if (f3_reg == pat_pkg::FUNC_COMPOSITE)
        begin
            sd_x = 33'(r3x_reg);
            sd_y = 33'(r3y_reg);
        end
        else
        begin
            sd_x = d3x_reg;
            sd_y = d3y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f4_reg  <= f3_reg;
            t4x_reg <= t3x_reg;
            t4y_reg <= t3y_reg;
            c4x_reg <= c3x_reg;
            c4y_reg <= c3y_reg;
            r4x_reg <= r3x_reg;
            r4y_reg <= r3y_reg;
            m4x_reg <= M_W'(sd_x) * M_W'(scale_x_reg);
            m4y_reg <= M_W'(sd_y) * M_W'(scale_y_reg);
            fl4_reg <= fl3_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: round scale, select result by operation
    // ---------------------------------------------------------------
    logic [32:0]        sx_sat, sy_sat;
    logic signed [31:0] res_x, res_y;
    logic               res_flag;
    logic signed [31:0] res_x_reg, res_y_reg;
    logic               sat_reg;

    always_comb
    begin
        sx_sat = sat(48'((m4x_reg + M_W'(128)) >>> 8) + 48'(c4x_reg));
        sy_sat = sat(48'((m4y_reg + M_W'(128)) >>> 8) + 48'(c4y_reg));
        case (f4_reg)
            pat_pkg::FUNC_TRANSLATE:
            begin
                res_x    = t4x_reg;
                res_y    = t4y_reg;
                res_flag = fl4_reg;
            end
            pat_pkg::FUNC_ROTATE:
            begin
                res_x    = r4x_reg;
                res_y    = r4y_reg;
                res_flag = fl4_reg;
            end
            default:
            begin
                res_x    = sx_sat[31:0];
                res_y    = sy_sat[31:0];
                res_flag = fl4_reg | sx_sat[32] | sy_sat[32];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_x_reg <= res_x;
            res_y_reg <= res_y;
            sat_reg   <= res_flag;
        end
    end

    assign result_x  = res_x_reg;
    assign result_y  = res_y_reg;
    assign saturated = sat_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> in_stall)
        else $error("item accepted while sine/cosine recompute is running");

    a_angle_restart: assert property (@(posedge clk) disable iff (!rst_n)
        angle_wr |=> busy_reg)
        else $error("angle write did not restart the CORDIC");

    a_item_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted item missing from first stage");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

    // Rows of the directed table: a register write or a point to transform.
    typedef enum logic {ROW_CFG, ROW_POINT} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [2:0]         index;
        logic [31:0]        data;
        pat_pkg::func_t     op;
        logic signed [31:0] px;
        logic signed [31:0] py;
        bit                 known;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        bit                 esat;
    } probe_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        bit                 sat;
    } point_res_t;

    localparam int         STAGES    = 16;
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int         DRAIN     = 12;
    localparam logic signed [31:0] PMAX = 32'sh7fffffff;
    localparam logic signed [31:0] PMIN = 32'sh80000000;

    localparam longint ATAN_TAB [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         func;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
    logic               saturated;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    point_affine_transform dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .point_x   (point_x),
        .point_y   (point_y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result_x  (result_x),
        .result_y  (result_y),
        .saturated (saturated),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the register file, updated on every accepted write.
    longint reg_shift_x, reg_shift_y, reg_angle;
    longint reg_scale_x, reg_scale_y, reg_pivot_x, reg_pivot_y;

    point_res_t pending_points[$];
    int         mismatches;
    int         sent_points;
    int         checked_points;
    int         saturated_seen;
    int         cfg_writes;
    bit         calm;   // no idling on either side while set

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Clamp to the signed 32-bit range and note any clamp.
    function automatic longint clamp32(input longint v, inout bit flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Sine and cosine in Q16 of a Q9.6 degree angle, by a rotation-mode CORDIC.
    function automatic void angle_trig(input longint ang, output longint s, output longint c);
        longint z, x, y, xs, ys;
        bit     flip;
        z = ang * 1024;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        while (z > 180 * 65536) z -= 360 * 65536;
        while (z < -180 * 65536) z += 360 * 65536;
        if (z > 90 * 65536)
        begin
            z -= 180 * 65536;
            flip = 1'b1;
        end
        else if (z < -90 * 65536)
        begin
            z += 180 * 65536;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= ATAN_TAB[i];
            end
            else
            begin
                x += ys;
                y -= xs;
                z += ATAN_TAB[i];
            end
        end
        x = (x + 8192) >>> 14;
        y = (y + 8192) >>> 14;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void rotate_about(inout longint px, inout longint py,
                                         input longint cx, input longint cy,
                                         inout bit flag);
        longint s, c, dx, dy;
        angle_trig(reg_angle, s, c);
        dx = px - cx;
        dy = py - cy;
        px = clamp32(((dx * c - dy * s + 32768) >>> 16) + cx, flag);
        py = clamp32(((dx * s + dy * c + 32768) >>> 16) + cy, flag);
    endfunction

    function automatic void scale_about(inout longint px, inout longint py,
                                        input longint cx, input longint cy,
                                        inout bit flag);
        longint dx, dy;
        dx = px - cx;
        dy = py - cy;
        px = clamp32(((dx * reg_scale_x + 128) >>> 8) + cx, flag);
        py = clamp32(((dy * reg_scale_y + 128) >>> 8) + cy, flag);
    endfunction

    function automatic point_res_t transform_point(input pat_pkg::func_t op,
                                                   input logic signed [31:0] ix,
                                                   input logic signed [31:0] iy);
        longint     x, y;
        bit         flag;
        point_res_t r;
        x = ix;
        y = iy;
        flag = 1'b0;
        case (op)
            pat_pkg::FUNC_TRANSLATE:
            begin
                x = clamp32(x + reg_shift_x, flag);
                y = clamp32(y + reg_shift_y, flag);
            end
            pat_pkg::FUNC_ROTATE: rotate_about(x, y, reg_pivot_x, reg_pivot_y, flag);
            pat_pkg::FUNC_SCALE:  scale_about(x, y, reg_pivot_x, reg_pivot_y, flag);
            default:
            begin
                // Composite: translate, rotate about origin, scale about origin.
                x = clamp32(x + reg_shift_x, flag);
                y = clamp32(y + reg_shift_y, flag);
                rotate_about(x, y, 0, 0, flag);
                scale_about(x, y, 0, 0, flag);
            end
        endcase
        r.x = x[31:0];
        r.y = y[31:0];
        r.sat = flag;
        return r;
    endfunction

    // Wait until every expected result has come back, then let the pipe drain.
    task automatic wait_idle();
        while (pending_points.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        @(negedge clk);
    endtask

    // Offer one register write; valid stays high so writes can follow back to back.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            pat_pkg::CFG_SHIFT_X:  reg_shift_x = $signed(data);
            pat_pkg::CFG_SHIFT_Y:  reg_shift_y = $signed(data);
            pat_pkg::CFG_ROTATION: reg_angle   = $signed(data[15:0]);
            pat_pkg::CFG_SCALE_X:  reg_scale_x = $signed(data[15:0]);
            pat_pkg::CFG_SCALE_Y:  reg_scale_y = $signed(data[15:0]);
            pat_pkg::CFG_PIVOT_X:  reg_pivot_x = $signed(data);
            pat_pkg::CFG_PIVOT_Y:  reg_pivot_y = $signed(data);
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
    endtask

    task automatic cfg_idle();
        cfg_valid <= 1'b0;
    endtask

    // Offer one point; keep valid high across back-to-back items.
    task automatic send_point(input pat_pkg::func_t op, input logic signed [31:0] px,
                              input logic signed [31:0] py, input bit known,
                              input point_res_t typed);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        point_x  <= px;
        point_y  <= py;
        do @(posedge clk); while (in_stall);
        pending_points.push_back(known ? typed : transform_point(op, px, py));
        sent_points++;
        @(negedge clk);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? PMAX - $urandom_range(0, 255)
                                                 : PMIN + $urandom_range(0, 255);
            default: return $signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000;
        endcase
    endfunction

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(0, 4))
            0:       return {16'h0, 16'($urandom())};
            default: return {16'h0, 16'($signed($urandom_range(0, 1024)) - 512)};
        endcase
    endfunction

    // Receiver: stall at random, check each delivered item against the oldest expectation.
    initial
    begin
        point_res_t want;
        int         hold;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = calm ? 0 : $urandom_range(0, 10);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            if (pending_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected item x=%0d y=%0d sat=%0b",
                             result_x, result_y, saturated);
            end
            else
            begin
                want = pending_points.pop_front();
                checked_points++;
                if (saturated) saturated_seen++;
                if (result_x !== want.x || result_y !== want.y || saturated !== want.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: item %0d got x=%0d y=%0d sat=%0b, ",
                                  "want x=%0d y=%0d sat=%0b"},
                                 checked_points, result_x, result_y, saturated,
                                 want.x, want.y, want.sat);
                end
            end
        end
    end

    // Hard stop in case the handshake hangs.
    initial
    begin
        #20ms;
        $display("ERROR: timeout");
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        // Directed rows. Translate and scale at reset settings are the identity,
        // so those expectations are typed in; all but one rotation row use the predictor.
        probe_t probes[] = '{
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_TRANSLATE, PMAX, PMAX, 1, PMAX, PMAX, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_TRANSLATE, PMIN, PMIN, 1, PMIN, PMIN, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_TRANSLATE, 32'sh55555555, 32'shaaaaaaaa,
              1, 32'sh55555555, 32'shaaaaaaaa, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_SCALE, PMAX, PMIN, 1, PMAX, PMIN, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_SCALE, 32'sd1, -32'sd1, 1,
              32'sd1, -32'sd1, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_ROTATE, 32'sd0, 32'sd0, 1,
              32'sd0, 32'sd0, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_ROTATE, PMIN, PMAX, 0, 0, 0, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_COMPOSITE, 32'sh00010000, PMAX,
              0, 0, 0, 0},
            // Translation to the rails: clamps both ways, and the exact fit.
            '{ROW_CFG, pat_pkg::CFG_SHIFT_X, 32'h7fffffff, pat_pkg::FUNC_TRANSLATE,
              0, 0, 0, 0, 0, 0},
            '{ROW_CFG, pat_pkg::CFG_SHIFT_Y, 32'h80000000, pat_pkg::FUNC_TRANSLATE,
              0, 0, 0, 0, 0, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_TRANSLATE, PMAX, PMIN, 1, PMAX, PMIN, 1},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_TRANSLATE, 32'sd0, 32'sd0, 1,
              PMAX, PMIN, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_TRANSLATE, PMIN, PMAX, 1,
              -32'sd1, -32'sd1, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_COMPOSITE, 32'sh00100000, 32'sh00100000,
              0, 0, 0, 0},
            // Angle beyond 180 (wraps), beyond 90 (folds), and the extremes.
            '{ROW_CFG, pat_pkg::CFG_ROTATION, 32'd19200, pat_pkg::FUNC_TRANSLATE,
              0, 0, 0, 0, 0, 0},
            '{ROW_CFG, pat_pkg::CFG_PIVOT_X, 32'h80000000, pat_pkg::FUNC_TRANSLATE,
              0, 0, 0, 0, 0, 0},
            '{ROW_CFG, pat_pkg::CFG_PIVOT_Y, 32'h7fffffff, pat_pkg::FUNC_TRANSLATE,
              0, 0, 0, 0, 0, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_ROTATE, PMAX, PMIN, 0, 0, 0, 0},
            '{ROW_CFG, pat_pkg::CFG_ROTATION, 32'd8640, pat_pkg::FUNC_TRANSLATE,
              0, 0, 0, 0, 0, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_ROTATE, 32'sd0, 32'sd0, 0, 0, 0, 0},
            '{ROW_CFG, pat_pkg::CFG_ROTATION, 32'hffffa600, pat_pkg::FUNC_TRANSLATE,
              0, 0, 0, 0, 0, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_COMPOSITE, PMIN, PMAX, 0, 0, 0, 0},
            // Scale factor extremes, plus a write to the unused index.
            '{ROW_CFG, pat_pkg::CFG_SCALE_X, 32'h00007fff, pat_pkg::FUNC_TRANSLATE,
              0, 0, 0, 0, 0, 0},
            '{ROW_CFG, pat_pkg::CFG_SCALE_Y, 32'h00008000, pat_pkg::FUNC_TRANSLATE,
              0, 0, 0, 0, 0, 0},
            '{ROW_CFG, CFG_UNUSED, 32'hffffffff, pat_pkg::FUNC_TRANSLATE, 0, 0, 0, 0, 0, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_SCALE, 32'sh12345678, 32'shedcba987,
              0, 0, 0, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_COMPOSITE, 32'sh00000100,
              -32'sh00000100, 0, 0, 0, 0},
            '{ROW_CFG, pat_pkg::CFG_ROTATION, 32'h00005a00, pat_pkg::FUNC_TRANSLATE,
              0, 0, 0, 0, 0, 0},
            '{ROW_CFG, pat_pkg::CFG_SCALE_X, 32'h00000000, pat_pkg::FUNC_TRANSLATE,
              0, 0, 0, 0, 0, 0},
            '{ROW_POINT, 3'd0, 32'd0, pat_pkg::FUNC_COMPOSITE, PMAX, PMAX, 0, 0, 0, 0}
        };
        point_res_t typed;
        bit         in_cfg;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = pat_pkg::FUNC_TRANSLATE;
        point_x     = '0;
        point_y     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = pat_pkg::CFG_SHIFT_X;
        cfg_data    = '0;
        calm        = 1'b0;
        mismatches  = 0;
        sent_points = 0;
        checked_points = 0;
        saturated_seen = 0;
        cfg_writes  = 0;
        reg_shift_x = 0;
        reg_shift_y = 0;
        reg_angle   = 0;
        reg_scale_x = 256;
        reg_scale_y = 256;
        reg_pivot_x = 0;
        reg_pivot_y = 0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table; drain before each run of register writes.
        in_cfg = 1'b0;
        foreach (probes[i])
        begin
            if (probes[i].kind == ROW_CFG)
            begin
                if (!in_cfg)
                begin
                    end_burst();
                    wait_idle();
                end
                in_cfg = 1'b1;
                write_reg(probes[i].index, probes[i].data);
            end
            else
            begin
                if (in_cfg)
                    cfg_idle();
                in_cfg = 1'b0;
                typed.x   = probes[i].ex;
                typed.y   = probes[i].ey;
                typed.sat = probes[i].esat;
                send_point(probes[i].op, probes[i].px, probes[i].py, probes[i].known, typed);
            end
        end
        end_burst();

        // Random phases: fresh settings, then a burst of random points.
        for (int phase = 0; phase < 9; phase++)
        begin
            wait_idle();
            calm = (phase % 3 == 2);
            write_reg(pat_pkg::CFG_SHIFT_X, rand_coord());
            write_reg(pat_pkg::CFG_SHIFT_Y, rand_coord());
            write_reg(pat_pkg::CFG_ROTATION, 32'($signed($urandom_range(0, 46080)) - 23040));
            write_reg(pat_pkg::CFG_SCALE_X, rand_scale());
            write_reg(pat_pkg::CFG_SCALE_Y, rand_scale());
            write_reg(pat_pkg::CFG_PIVOT_X, rand_coord());
            write_reg(pat_pkg::CFG_PIVOT_Y, rand_coord());
            if (phase == 4) write_reg(CFG_UNUSED, $urandom());
            cfg_idle();
            for (int n = 0; n < 205; n++)
                send_point(pat_pkg::func_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                           0, typed);
            end_burst();
        end

        wait_idle();
        calm = 1'b0;
        if (pending_points.size() != 0)
        begin
            mismatches++;
            $display("ERROR: %0d items never came back", pending_points.size());
        end

        $display("Sent %0d points over %0d register writes; %0d results checked, %0d saturated.",
                 sent_points, cfg_writes, checked_points, saturated_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
